// ===== hdl/sbn_pkg.sv =====
// Package for the stroke box normalizer.
// Holds the fixed stroke-number width and the one-pixel minimum span.
// No dependencies.
package sbn_pkg;

  localparam int STROKE_W = 6;
  localparam logic [STROKE_W-1:0] STROKE_MAX = 6'd63;
  localparam int ONE_PIXEL = 16;

endpackage

// ===== hdl/sbn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the point store of the stroke box normalizer. No dependencies.
module sbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                     wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/stroke_box_normalizer_unit.sv =====
// Stroke box normalizer: buffers the pen points of one character and emits them
// scaled and centred onto a square canvas. Depends on sbn_pkg and sbn_ram.
//
//   channel  | handshake        | beat contents
//   ---------+------------------+-----------------------------------------------
//   point in | start, busy      | x_pos, y_pos, stroke_end, char_end
//   result   | done (strobe)    | stroke_index, canvas_x, canvas_y, last, overflow
//
// A point without char_end is taken while idle and busy stays low.
// On char_end the block goes busy: S_SPAN and S_PAD set up the box, then each
// buffered point passes S_FETCH and, once per axis, S_TERM, S_MUL, S_NUM and the
// one-bit-a-cycle restoring divider S_DIV that is shared between the x and y coordinates.
// Each result is shown for one cycle on done; the receiver cannot stall it.
// Reset is synchronous and clears the point count, box, stroke number and flag.
module stroke_box_normalizer_unit
  import sbn_pkg::*;
#(
  parameter int MAX_POINTS = 64,
  parameter int CANVAS     = 256,
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [COORD_BITS-1:0]         x_pos,
  input  logic [COORD_BITS-1:0]         y_pos,
  input  logic                          stroke_end,
  input  logic                          char_end,
  output logic                          done,
  output logic [STROKE_W-1:0]           stroke_index,
  output logic [$clog2(CANVAS)-1:0]     canvas_x,
  output logic [$clog2(CANVAS)-1:0]     canvas_y,
  output logic                          last,
  output logic                          overflow
);

  localparam int QW   = $clog2(CANVAS);
  localparam int CB   = COORD_BITS;
  localparam int NW   = CB + 1 + QW;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int AW   = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
  localparam int DW   = 2 * CB + STROKE_W;
  localparam int QCW  = QW > 1 ? $clog2(QW) : 1;
  localparam logic [QW-1:0] CMUL   = QW'(CANVAS - 1);
  localparam logic [CW-1:0] CAP    = CW'(MAX_POINTS);
  localparam logic [CB-1:0] MINSPAN = CB'(ONE_PIXEL);

  typedef enum logic [2:0] {
    S_IDLE, S_SPAN, S_PAD, S_FETCH, S_TERM, S_MUL, S_NUM, S_DIV
  } state_t;

  state_t              state;
  logic [CW-1:0]       point_count;
  logic [CW-1:0]       idx;
  logic [CB-1:0]       min_x, min_y, max_x, max_y;
  logic [CB-1:0]       ext_x, ext_y, span, pad_x, pad_y;
  logic [CB:0]         den;
  logic [STROKE_W-1:0] stroke_counter;
  logic                dropped_flag;
  logic                axis;
  logic [CB:0]         term;
  logic [NW-1:0]       prod;
  logic [CB:0]         rem;
  logic [QW-1:0]       num_low;
  logic [QW-1:0]       quo;
  logic [QCW-1:0]      step;

  logic                accept, store_pt, ends;
  logic [DW-1:0]       wr_data, rd_data;
  logic [CB-1:0]       rd_x, rd_y, sel_v, sel_lo, sel_pad, diff;
  logic [STROKE_W-1:0] rd_stroke;
  logic [NW-1:0]       num;
  logic [CB+1:0]       trial;
  logic [CB+1:0]       trial_sub;
  logic                qbit;
  logic [QW:0]         quo_shift;
  logic [QW-1:0]       quo_next;
  logic                last_pt;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign store_pt = accept && (point_count < CAP);
  assign ends     = stroke_end || char_end;
  assign wr_data  = {x_pos, y_pos, stroke_counter};

  sbn_ram #(
    .WIDTH(DW),
    .DEPTH(MAX_POINTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (store_pt),
    .wr_addr(point_count[AW-1:0]),
    .wr_data(wr_data),
    .rd_addr(idx[AW-1:0]),
    .rd_data(rd_data)
  );

  assign rd_x      = rd_data[DW-1 -: CB];
  assign rd_y      = rd_data[STROKE_W +: CB];
  assign rd_stroke = rd_data[STROKE_W-1:0];

  assign sel_v   = axis ? rd_y : rd_x;
  assign sel_lo  = axis ? min_y : min_x;
  assign sel_pad = axis ? pad_y : pad_x;
  assign diff    = sel_v - sel_lo;

  assign num       = prod + NW'(span);
  assign trial     = {rem, num_low[QW-1]};
  assign trial_sub = trial - {1'b0, den};
  assign qbit      = (trial >= {1'b0, den});
  assign quo_shift = {quo, qbit};
  assign quo_next  = quo_shift[QW-1:0];
  assign last_pt   = ((idx + CW'(1)) == point_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      point_count    <= '0;
      min_x          <= '0;
      min_y          <= '0;
      max_x          <= '0;
      max_y          <= '0;
      stroke_counter <= '0;
      dropped_flag   <= 1'b0;
      done           <= 1'b0;
      idx            <= '0;
      axis           <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (store_pt) begin
              if (point_count == '0) begin
                min_x <= x_pos;
                max_x <= x_pos;
                min_y <= y_pos;
                max_y <= y_pos;
              end else begin
                if (x_pos < min_x) min_x <= x_pos;
                if (x_pos > max_x) max_x <= x_pos;
                if (y_pos < min_y) min_y <= y_pos;
                if (y_pos > max_y) max_y <= y_pos;
              end
              point_count <= point_count + CW'(1);
            end else begin
              dropped_flag <= 1'b1;
            end
            if (ends && stroke_counter != STROKE_MAX) begin
              stroke_counter <= stroke_counter + STROKE_W'(1);
            end
            if (char_end) begin
              state <= S_SPAN;
            end
          end
        end
        S_SPAN: begin
          ext_x <= max_x - min_x;
          ext_y <= max_y - min_y;
          state <= S_PAD;
        end
        S_PAD: begin
          if (ext_x < MINSPAN && ext_y < MINSPAN) begin
            span  <= MINSPAN;
            pad_x <= MINSPAN - ext_x;
            pad_y <= MINSPAN - ext_y;
            den   <= {MINSPAN, 1'b0};
          end else if (ext_x > ext_y) begin
            span  <= ext_x;
            pad_x <= '0;
            pad_y <= ext_x - ext_y;
            den   <= {ext_x, 1'b0};
          end else begin
            span  <= ext_y;
            pad_x <= ext_y - ext_x;
            pad_y <= '0;
            den   <= {ext_y, 1'b0};
          end
          idx   <= '0;
          axis  <= 1'b0;
          state <= S_FETCH;
        end
        S_FETCH: begin
          state <= S_TERM;
        end
        S_TERM: begin
          term  <= {diff, 1'b0} + (CB+1)'(sel_pad);
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= NW'(term) * NW'(CMUL);
          state <= S_NUM;
        end
        S_NUM: begin
          rem     <= num[NW-1:QW];
          num_low <= num[QW-1:0];
          quo     <= '0;
          step    <= QCW'(QW - 1);
          state   <= S_DIV;
        end
        S_DIV: begin
          rem     <= qbit ? trial_sub[CB:0] : trial[CB:0];
          num_low <= num_low << 1;
          quo     <= quo_next;
          step    <= step - QCW'(1);
          if (step == '0) begin
            if (!axis) begin
              canvas_x <= quo_next;
              axis     <= 1'b1;
              state    <= S_TERM;
            end else begin
              canvas_y     <= quo_next;
              stroke_index <= rd_stroke;
              last         <= last_pt;
              overflow     <= dropped_flag;
              done         <= 1'b1;
              axis         <= 1'b0;
              idx          <= idx + CW'(1);
              if (last_pt) begin
                point_count    <= '0;
                min_x          <= '0;
                min_y          <= '0;
                max_x          <= '0;
                max_y          <= '0;
                stroke_counter <= '0;
                dropped_flag   <= 1'b0;
                state          <= S_IDLE;
              end else begin
                state <= S_FETCH;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_idle_result_is_last: assert property (@(posedge clk) disable iff (rst)
    done && !busy |-> last)
    else $error("result shown while idle is not the final one");

  a_char_end_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && char_end |=> busy)
    else $error("character end did not start the output phase");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    point_count <= CAP)
    else $error("point count beyond buffer capacity");

  a_single_cycle_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results on adjacent cycles");

endmodule
